FILE: rtl/ndd_pkg.sv
package ndd_pkg;

  localparam int unsigned WORD_BITS_DEF = 64;
  localparam int unsigned WORD_BITS_MIN = 8;
  localparam int unsigned WORD_BITS_MAX = 64;

endpackage

FILE: rtl/ndd_cell.sv
module ndd_cell #(
  parameter int unsigned WORD_BITS = ndd_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic                 ovf_i,
  input  logic [WORD_BITS-1:0] rem_i,
  input  logic [WORD_BITS-1:0] quo_i,
  input  logic [WORD_BITS-1:0] low_i,
  input  logic [WORD_BITS-1:0] div_i,
  output logic                 valid_o,
  output logic                 ovf_o,
  output logic [WORD_BITS-1:0] rem_o,
  output logic [WORD_BITS-1:0] quo_o,
  output logic [WORD_BITS-1:0] low_o,
  output logic [WORD_BITS-1:0] div_o
);

  logic                 valid_r;
  logic                 ovf_r;
  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [WORD_BITS-1:0] quo_r, quo_nxt;
  logic [WORD_BITS-1:0] low_r, low_nxt;
  logic [WORD_BITS-1:0] div_r;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;
  logic                 take;

  // shifted partial remainder keeps its carry-out bit, so trial < 2*divisor
  assign trial = {rem_i, low_i[WORD_BITS-1]};
  assign diff  = trial - {1'b0, div_i};
  assign take  = !diff[WORD_BITS];

  always_comb begin
    rem_nxt = take ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
    quo_nxt = {quo_i[WORD_BITS-2:0], take};
    low_nxt = {low_i[WORD_BITS-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r <= ovf_i;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      low_r <= low_nxt;
      div_r <= div_i;
    end
  end

  assign valid_o = valid_r;
  assign ovf_o   = ovf_r;
  assign rem_o   = rem_r;
  assign quo_o   = quo_r;
  assign low_o   = low_r;
  assign div_o   = div_r;

endmodule

FILE: rtl/narrowing_divide_double_word_unit.sv
// channel | dir | tdata (low bit up)                          | tuser
// in_     | in  | dividend_high, dividend_low, divisor, pad    | -
// out_    | out | quotient, remainder, pad                     | overflow
//
// Fully pipelined: one transfer per cycle sustained while out_ is not stalled; one input
// register plus one restoring-subtract cell per quotient bit.
// Reset (rst_n low, synchronous) clears all stage valid bits.
// A stall on out_ holds the whole chain; in_tready follows it in the same cycle.
// Overflow (dividend_high >= divisor, includes zero divisor) saturates both results.
module narrowing_divide_double_word_unit #(
  parameter int unsigned WORD_BITS = ndd_pkg::WORD_BITS_DEF,
  localparam int unsigned IN_W  = ((3 * WORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * WORD_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // dividend_high, dividend_low, divisor
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // quotient, remainder
  output logic [0:0]       out_tuser   // overflow
);

  logic                 en;
  logic [WORD_BITS-1:0] in_hi, in_lo, in_div;

  logic                 valid_s [0:WORD_BITS];
  logic                 ovf_s   [0:WORD_BITS];
  logic [WORD_BITS-1:0] rem_s   [0:WORD_BITS];
  logic [WORD_BITS-1:0] quo_s   [0:WORD_BITS];
  logic [WORD_BITS-1:0] low_s   [0:WORD_BITS];
  logic [WORD_BITS-1:0] div_s   [0:WORD_BITS];

  logic                 valid_r;
  logic                 ovf_r;
  logic [WORD_BITS-1:0] rem_r, low_r, div_r;

  assign in_hi  = in_tdata[WORD_BITS-1:0];
  assign in_lo  = in_tdata[2*WORD_BITS-1:WORD_BITS];
  assign in_div = in_tdata[3*WORD_BITS-1:2*WORD_BITS];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r <= (in_hi >= in_div);
      rem_r <= in_hi;
      low_r <= in_lo;
      div_r <= in_div;
    end
  end

  assign valid_s[0] = valid_r;
  assign ovf_s[0]   = ovf_r;
  assign rem_s[0]   = rem_r;
  assign quo_s[0]   = '0;
  assign low_s[0]   = low_r;
  assign div_s[0]   = div_r;

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    ndd_cell #(
      .WORD_BITS(WORD_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .valid_i(valid_s[i]),
      .ovf_i  (ovf_s[i]),
      .rem_i  (rem_s[i]),
      .quo_i  (quo_s[i]),
      .low_i  (low_s[i]),
      .div_i  (div_s[i]),
      .valid_o(valid_s[i+1]),
      .ovf_o  (ovf_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .quo_o  (quo_s[i+1]),
      .low_o  (low_s[i+1]),
      .div_o  (div_s[i+1])
    );
  end

  assign out_tvalid = valid_s[WORD_BITS];
  assign out_tuser  = ovf_s[WORD_BITS];
  assign out_tdata  = ovf_s[WORD_BITS] ? OUT_W'({2 * WORD_BITS{1'b1}})
                                       : OUT_W'({rem_s[WORD_BITS], quo_s[WORD_BITS]});

endmodule

FILE: tb/sv/narrowing_divide_double_word_unit_test.sv
`timescale 1ns / 100ps

module narrowing_divide_double_word_unit_test;

  localparam int unsigned WB    = ndd_pkg::WORD_BITS_DEF;
  localparam int unsigned IN_W  = ((3 * WB + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((2 * WB + 7) / 8) * 8;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned STALL_LIMIT  = 2000;

  typedef logic [WB-1:0]   word_t;
  typedef bit [2*WB-1:0]   dword_t;

  localparam word_t ONES = '1;
  localparam word_t MSB  = word_t'(1) << (WB - 1);

  class quotient_tracker;
    typedef struct {
      word_t quotient;
      word_t remainder;
      logic  overflow;
    } division_t;

    division_t pending_divisions[$];
    int unsigned mismatches;

    function division_t divide_words(word_t hi, word_t lo, word_t d);
      division_t res;
      dword_t    num;
      if (hi >= d) begin
        res.quotient  = ONES;
        res.remainder = ONES;
        res.overflow  = 1'b1;
      end else begin
        num           = {hi, lo};
        res.quotient  = word_t'(num / dword_t'(d));
        res.remainder = word_t'(num % dword_t'(d));
        res.overflow  = 1'b0;
      end
      return res;
    endfunction

    function void note_input(word_t hi, word_t lo, word_t d);
      pending_divisions.push_back(divide_words(hi, lo, d));
    endfunction

    function void check_result(word_t q, word_t r, logic ovf);
      division_t exp_div;
      if (pending_divisions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result q=%h r=%h ovf=%b", q, r, ovf);
        return;
      end
      exp_div = pending_divisions.pop_front();
      if (q !== exp_div.quotient || r !== exp_div.remainder || ovf !== exp_div.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp q=%h r=%h ovf=%b, got q=%h r=%h ovf=%b",
                   exp_div.quotient, exp_div.remainder, exp_div.overflow, q, r, ovf);
      end
    endfunction

    function int unsigned outstanding();
      return pending_divisions.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // dividend_high, dividend_low, divisor
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // quotient, remainder
  logic [0:0]       out_tuser;  // overflow

  quotient_tracker tracker = new();
  bit              no_idle;
  int unsigned     stall_cycles = 0;

  narrowing_divide_double_word_unit #(
    .WORD_BITS(WB)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    if (no_idle || $urandom_range(0, 1) == 0)
      return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic word_t rand_word();
    return word_t'({$urandom, $urandom});
  endfunction

  task automatic send_division(input word_t hi, input word_t lo, input word_t d);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({d, lo, hi});
    do @(posedge clk); while (!in_tready);
    tracker.note_input(hi, lo, d);
  endtask

  task automatic send_random_division();
    word_t hi, lo, d;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    lo   = rand_word();
    case (kind)
      7: begin
        d  = word_t'($urandom_range(1, 255));
        hi = rand_word() % d;
      end
      8: begin
        d  = rand_word() >> $urandom_range(0, WB - 1);
        hi = d | rand_word();
      end
      9: begin
        d  = ($urandom_range(0, 1) == 0) ? word_t'(0) : ONES;
        hi = ($urandom_range(0, 1) == 0) ? rand_word() : ONES - word_t'(1);
      end
      5, 6: begin
        d  = rand_word();
        hi = rand_word();
      end
      default: begin
        d  = rand_word() >> $urandom_range(0, WB - 1);
        if (d == 0)
          d = word_t'(1);
        hi = rand_word() % d;
      end
    endcase
    send_division(hi, lo, d);
  endtask

  // result side
  initial begin
    int unsigned gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(out_tdata[WB-1:0], out_tdata[2*WB-1:WB], out_tuser[0]);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    no_idle      = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero divisor and saturation cases
    send_division('0, '0, '0);
    send_division(ONES, ONES, '0);
    send_division(word_t'(5), rand_word(), word_t'(5));
    send_division(ONES, ONES, ONES);
    send_division(word_t'(10), '0, word_t'(3));
    // largest quotients and extreme divisors
    send_division('0, ONES, word_t'(1));
    send_division('0, '0, word_t'(1));
    send_division(ONES - word_t'(1), ONES, ONES);
    send_division(ONES - word_t'(1), '0, ONES);
    send_division('0, '0, ONES);
    send_division('0, ONES, ONES);
    send_division(word_t'(1), '0, word_t'(2));
    send_division('0, word_t'(1), word_t'(2));
    send_division('0, MSB, MSB);
    send_division(MSB - word_t'(1), ONES, MSB);
    send_division('0, word_t'(12345), word_t'(7));
    send_division({(WB/2){2'b01}}, {(WB/2){2'b10}}, {(WB/2){2'b10}});
    send_division({(WB/2){2'b10}}, {(WB/2){2'b01}}, ONES);
    send_division('0, ONES, word_t'(1) << (WB / 2));
    send_division((word_t'(1) << (WB / 2)) - word_t'(1), '0, word_t'(1) << (WB / 2));

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0)
        no_idle = ($urandom_range(0, 2) == 0);
      send_random_division();
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;

    while (tracker.outstanding() > 0) @(posedge clk);
    repeat (3 * (WB + 1)) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
